// File: rtl/lprt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprt_pkg: shared types and constants for the lidar point transform
// Field widths, register indexes and the stage enable bundle.
// ----------------------------------------------------------------------------
package lprt_pkg;

  localparam int LPRT_COEF_WIDTH = 16;   // default coefficient width (Q1.14)
  localparam int RAW_W           = 32;   // raw coordinate width
  localparam int PNT_W           = 36;   // coordinate in mm after cm scaling
  localparam int OUT_W           = 40;   // result coordinate width
  localparam int OUT_FRAC        = 4;    // result fraction bits
  localparam int TRANS_W         = 21;   // translation offset width
  localparam int BYTE_W          = 8;
  localparam int TIME_W          = 64;
  localparam int INTV_W          = 32;
  localparam int CFG_DATA_W      = 63;   // widest register
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X      = 3'd0,
    REG_ROT_Y      = 3'd1,
    REG_ROT_Z      = 3'd2,
    REG_TRANSLATE  = 3'd3,
    REG_PASS       = 3'd4,
    REG_LINE_COUNT = 3'd5
  } cfg_reg_t;

  // Load enables of the coordinate pipeline stages.
  typedef struct packed {
    logic s;   // scaled point
    logic p;   // products
    logic r;   // result register
  } lprt_stage_en_t;

endpackage

// File: rtl/lprt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprt_in_if / lprt_out_if: point and result channels
// Valid/ready channels carrying one raw point or one transformed point.
// ----------------------------------------------------------------------------
interface lprt_in_if;
  import lprt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RAW_W-1:0]  raw_x;
  logic signed [RAW_W-1:0]  raw_y;
  logic signed [RAW_W-1:0]  raw_z;
  logic [BYTE_W-1:0]        reflectivity;
  logic [BYTE_W-1:0]        point_tag;
  logic                     low_resolution;
  logic                     first_point;
  logic [TIME_W-1:0]        packet_time_ns;
  logic [INTV_W-1:0]        point_interval_ns;

  modport source (output valid, raw_x, raw_y, raw_z, reflectivity, point_tag,
                  low_resolution, first_point, packet_time_ns, point_interval_ns,
                  input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, reflectivity, point_tag,
                  low_resolution, first_point, packet_time_ns, point_interval_ns,
                  output ready);
endinterface

interface lprt_out_if;
  import lprt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  out_x;
  logic signed [OUT_W-1:0]  out_y;
  logic signed [OUT_W-1:0]  out_z;
  logic [BYTE_W-1:0]        intensity;
  logic [BYTE_W-1:0]        line_number;
  logic [BYTE_W-1:0]        out_tag;
  logic [TIME_W-1:0]        point_time_ns;

  modport source (output valid, out_x, out_y, out_z, intensity, line_number, out_tag,
                  point_time_ns, input ready);
  modport sink   (input valid, out_x, out_y, out_z, intensity, line_number, out_tag,
                  point_time_ns, output ready);
endinterface

// File: rtl/lprt_coord_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprt_coord_path: coordinate datapath
// Scale to mm, multiply by the rotation, add translation, shift and saturate.
// ----------------------------------------------------------------------------
module lprt_coord_path #(
  parameter int COEF_WIDTH = lprt_pkg::LPRT_COEF_WIDTH
) (
  input  logic                                   clk,
  input  lprt_pkg::lprt_stage_en_t               en,
  input  logic signed [lprt_pkg::RAW_W-1:0]      raw [3],
  input  logic                                   low_res,
  input  logic signed [COEF_WIDTH-1:0]           coef [3][3],
  input  logic signed [lprt_pkg::TRANS_W-1:0]    trans [3],
  input  logic                                   pass_through,
  output logic signed [lprt_pkg::OUT_W-1:0]      result [3]
);
  import lprt_pkg::*;

  localparam int FRAC_BITS = COEF_WIDTH - 2;
  localparam int SHIFT     = FRAC_BITS - OUT_FRAC;
  localparam int PROD_W    = PNT_W + COEF_WIDTH;
  localparam int SUM_W     = PROD_W + 2;

  logic signed [PNT_W-1:0]  pnt_s_r  [3];
  logic signed [PROD_W-1:0] prod_p_r [3][3];
  logic signed [OUT_W-1:0]  pass_p_r [3];
  logic signed [OUT_W-1:0]  res_r    [3];
  logic signed [SUM_W-1:0]  sum      [3];
  logic signed [SUM_W-1:0]  sum_sh   [3];
  logic signed [OUT_W-1:0]  res_nxt  [3];

  // scale cm to mm as x*8 + x*2
  always_ff @(posedge clk) begin
    if (en.s) begin
      for (int r = 0; r < 3; r++) begin
        if (low_res) begin
          pnt_s_r[r] <= (PNT_W'(raw[r]) <<< 3) + (PNT_W'(raw[r]) <<< 1);
        end else begin
          pnt_s_r[r] <= PNT_W'(raw[r]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.p) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_p_r[r][c] <= PROD_W'(pnt_s_r[c]) * PROD_W'(coef[r][c]);
        end
        pass_p_r[r] <= {pnt_s_r[r], {OUT_FRAC{1'b0}}};
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_W'(prod_p_r[r][0]) + SUM_W'(prod_p_r[r][1]) + SUM_W'(prod_p_r[r][2])
             + (SUM_W'(trans[r]) <<< FRAC_BITS);
      sum_sh[r] = sum[r] >>> SHIFT;
      // saturate when the sign bit and the bits above it disagree
      if ((&sum_sh[r][SUM_W-1:OUT_W-1]) || !(|sum_sh[r][SUM_W-1:OUT_W-1])) begin
        res_nxt[r] = sum_sh[r][OUT_W-1:0];
      end else if (sum_sh[r][SUM_W-1]) begin
        res_nxt[r] = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        res_nxt[r] = {1'b0, {(OUT_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.r) begin
      for (int r = 0; r < 3; r++) begin
        res_r[r] <= pass_through ? pass_p_r[r] : res_nxt[r];
      end
    end
  end

  assign result = res_r;

endmodule

// File: rtl/lidar_point_rigid_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_rigid_transform: rigid-body transform of Cartesian lidar points
// Rotates and translates each point, stamps line number and point time.
// ----------------------------------------------------------------------------
// Takes one point per clock and returns one transformed point per clock when
// the result side keeps ready high; each item passes the input register,
// the scaling stage, the multiplier stage and the result register in turn.
// In the multiplier stage nine coordinate-by-coefficient products are
// registered before the sum, shift and saturation. Each stage
// loads whenever it is empty or the stage after it moves, so new points keep
// entering while a finished result waits for ready. Line number and point
// time are assigned in order as items leave the input register. Write the
// configuration registers only while no item is in flight.
// ----------------------------------------------------------------------------
module lidar_point_rigid_transform #(
  parameter int COEF_WIDTH = lprt_pkg::LPRT_COEF_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lprt_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lprt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  lprt_in_if.sink                             in_ch,
  lprt_out_if.source                          out_ch
);
  import lprt_pkg::*;

  localparam int FRAC_BITS = COEF_WIDTH - 2;
  localparam int EXT_W = (3 * COEF_WIDTH > CFG_DATA_W) ? 3 * COEF_WIDTH : CFG_DATA_W;
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << FRAC_BITS;

  // configuration
  logic signed [COEF_WIDTH-1:0] coef_r  [3][3];
  logic signed [TRANS_W-1:0]    trans_r [3];
  logic                         pass_r;
  logic [BYTE_W-1:0]            line_count_r;
  logic [EXT_W-1:0]             cfg_ext;

  // sequencing state
  logic [BYTE_W-1:0] line_pos_r;
  logic [TIME_W-1:0] time_acc_r;

  // stage valids and enables
  logic           a_vld_r, s_vld_r, p_vld_r, out_vld_r;
  logic           en_a;
  lprt_stage_en_t en;

  // input register
  logic signed [RAW_W-1:0] a_raw_r [3];
  logic                    a_low_r, a_first_r;
  logic [BYTE_W-1:0]       a_refl_r, a_tag_r;
  logic [TIME_W-1:0]       a_ptime_r;
  logic [INTV_W-1:0]       a_intv_r;

  // sideband carried alongside the coordinates
  logic [BYTE_W-1:0] s_refl_r, s_tag_r, s_line_r;
  logic [TIME_W-1:0] s_time_r;
  logic [BYTE_W-1:0] p_refl_r, p_tag_r, p_line_r;
  logic [TIME_W-1:0] p_time_r;
  logic [BYTE_W-1:0] o_refl_r, o_tag_r, o_line_r;
  logic [TIME_W-1:0] o_time_r;

  logic [BYTE_W-1:0] cnt_eff, line_cur, line_pos_nxt;
  logic [TIME_W-1:0] time_cur, time_acc_nxt;
  logic [BYTE_W:0]   line_inc;

  logic signed [OUT_W-1:0] result [3];

  // ---------------------------------------------------------------- config
  assign cfg_ext = EXT_W'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          coef_r[r][c] <= (r == c) ? COEF_ONE : '0;
        end
        trans_r[r] <= '0;
      end
      pass_r       <= 1'b0;
      line_count_r <= BYTE_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROT_X: begin
          for (int k = 0; k < 3; k++) coef_r[0][k] <= cfg_ext[k*COEF_WIDTH +: COEF_WIDTH];
        end
        REG_ROT_Y: begin
          for (int k = 0; k < 3; k++) coef_r[1][k] <= cfg_ext[k*COEF_WIDTH +: COEF_WIDTH];
        end
        REG_ROT_Z: begin
          for (int k = 0; k < 3; k++) coef_r[2][k] <= cfg_ext[k*COEF_WIDTH +: COEF_WIDTH];
        end
        REG_TRANSLATE: begin
          for (int k = 0; k < 3; k++) trans_r[k] <= cfg_wdata[k*TRANS_W +: TRANS_W];
        end
        REG_PASS: begin
          pass_r <= cfg_wdata[0];
        end
        REG_LINE_COUNT: begin
          line_count_r <= cfg_wdata[BYTE_W-1:0];
        end
        default: begin
          // unused indexes: drop the write
        end
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  // A stage loads when it is empty or its contents move on.
  assign en.r = !out_vld_r || out_ch.ready;
  assign en.p = !p_vld_r || en.r;
  assign en.s = !s_vld_r || en.p;
  assign en_a = !a_vld_r || en.s;

  assign in_ch.ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      s_vld_r   <= 1'b0;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en_a) a_vld_r   <= in_ch.valid;
      if (en.s) s_vld_r   <= a_vld_r;
      if (en.p) p_vld_r   <= s_vld_r;
      if (en.r) out_vld_r <= p_vld_r;
    end
  end

  // ------------------------------------------------------- input register
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_raw_r[0] <= in_ch.raw_x;
      a_raw_r[1] <= in_ch.raw_y;
      a_raw_r[2] <= in_ch.raw_z;
      a_low_r    <= in_ch.low_resolution;
      a_first_r  <= in_ch.first_point;
      a_refl_r   <= in_ch.reflectivity;
      a_tag_r    <= in_ch.point_tag;
      a_ptime_r  <= in_ch.packet_time_ns;
      a_intv_r   <= in_ch.point_interval_ns;
    end
  end

  // ------------------------------------------------- line and time stamps
  // A zero line count acts as one; a stale position past the count restarts.
  always_comb begin
    cnt_eff = (line_count_r == '0) ? BYTE_W'(1) : line_count_r;
    if (a_first_r) begin
      line_cur = '0;
      time_cur = a_ptime_r;
    end else begin
      line_cur = (line_pos_r >= cnt_eff) ? '0 : line_pos_r;
      time_cur = time_acc_r;
    end
    line_inc     = {1'b0, line_cur} + (BYTE_W+1)'(1);
    line_pos_nxt = (line_inc >= {1'b0, cnt_eff}) ? '0 : line_inc[BYTE_W-1:0];
    time_acc_nxt = time_cur + TIME_W'(a_intv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r <= '0;
      time_acc_r <= '0;
    end else if (en.s && a_vld_r) begin
      line_pos_r <= line_pos_nxt;
      time_acc_r <= time_acc_nxt;
    end
  end

  // ------------------------------------------------------ sideband stages
  always_ff @(posedge clk) begin
    if (en.s) begin
      s_refl_r <= a_refl_r;
      s_tag_r  <= a_tag_r;
      s_line_r <= line_cur;
      s_time_r <= time_cur;
    end
    if (en.p) begin
      p_refl_r <= s_refl_r;
      p_tag_r  <= s_tag_r;
      p_line_r <= s_line_r;
      p_time_r <= s_time_r;
    end
    if (en.r) begin
      o_refl_r <= p_refl_r;
      o_tag_r  <= p_tag_r;
      o_line_r <= p_line_r;
      o_time_r <= p_time_r;
    end
  end

  // ---------------------------------------------------- coordinate stages
  lprt_coord_path #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_coord (
    .clk          (clk),
    .en           (en),
    .raw          (a_raw_r),
    .low_res      (a_low_r),
    .coef         (coef_r),
    .trans        (trans_r),
    .pass_through (pass_r),
    .result       (result)
  );

  // --------------------------------------------------------------- output
  assign out_ch.valid         = out_vld_r;
  assign out_ch.out_x         = result[0];
  assign out_ch.out_y         = result[1];
  assign out_ch.out_z         = result[2];
  assign out_ch.intensity     = o_refl_r;
  assign out_ch.line_number   = o_line_r;
  assign out_ch.out_tag       = o_tag_r;
  assign out_ch.point_time_ns = o_time_r;

  // ----------------------------------------------------------- assertions
  // first point of a packet leaves the next line at one, or zero for one line
  a_first_line: assert property (@(posedge clk) disable iff (!rst_n)
    (en.s && a_vld_r && a_first_r) |=>
      (line_pos_r == BYTE_W'(1) || ($past(cnt_eff) == BYTE_W'(1) && line_pos_r == '0)))
    else $error("line position after first point wrong");

  // time accumulator advances by the interval of each item that moves on
  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    (en.s && a_vld_r) |=> (time_acc_r == $past(time_cur + TIME_W'(a_intv_r))))
    else $error("time accumulator did not advance by the point interval");

  // an item in the multiplier stage reaches the output when the result moves
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && en.r) |=> out_vld_r)
    else $error("item lost between multiplier stage and output");

  // an empty output register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty output register");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lidar_point_rigid_transform
// Streams directed and random lidar points through the transform under
// several configurations and handshake pressures. Each item is checked field
// by field against an in-bench transform model, or a result typed in by hand
// for typed rows; the model tracks the scan-line and point-time state.
// ----------------------------------------------------------------------------
module tb;
  import lprt_pkg::*;

  localparam int    FRAC        = LPRT_COEF_WIDTH - 2;   // coefficient fraction bits
  localparam int    HOLD_CYCLES = 300;                   // long receiver hold-off
  localparam int    CYCLE_LIMIT = 200000;
  localparam int    AWAIT_DEPTH = 16;                    // well above the items in flight
  localparam int    ROW_DEPTH   = 64;                    // directed table capacity
  localparam longint SAT_HI     = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint SAT_LO     = -(longint'(1) <<< (OUT_W - 1));
  localparam logic [47:0] ROT_ONE = 48'(1) << FRAC;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic [BYTE_W-1:0]       reflectivity;
    logic [BYTE_W-1:0]       point_tag;
    logic                    low_resolution;
    logic                    first_point;
    logic [TIME_W-1:0]       packet_time_ns;
    logic [INTV_W-1:0]       point_interval_ns;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic [BYTE_W-1:0]       intensity;
    logic [BYTE_W-1:0]       line_number;
    logic [BYTE_W-1:0]       out_tag;
    logic [TIME_W-1:0]       point_time_ns;
  } xf_result_t;

  typedef enum bit {ROW_CFG, ROW_PT} row_kind_t;

  // One line of the directed table: a register write or a point, the latter
  // optionally with its result typed in by hand.
  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    ridx;
    logic [62:0] rval;
    point_t      pt;
    bit          typed;
    xf_result_t  want;
  } vec_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lprt_in_if  in_ch ();
  lprt_out_if out_ch ();

  lidar_point_rigid_transform i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Transform model state: configuration copy plus packet tracking.
  logic signed [LPRT_COEF_WIDTH-1:0] rot_coef [3][3];
  logic signed [TRANS_W-1:0]         trans_mm [3];
  logic                              pass_en;
  logic [BYTE_W-1:0]                 lines_per_scan;
  logic [BYTE_W-1:0]                 next_line;
  logic [TIME_W-1:0]                 next_time;

  // transformed points not yet seen on the output, oldest at await_rd
  xf_result_t awaited_ring [AWAIT_DEPTH];
  int         await_wr = 0;
  int         await_rd = 0;
  vec_row_t   dir_rows [ROW_DEPTH];
  int         dir_cnt  = 0;

  int mismatch_cnt = 0;
  int results_seen = 0;
  int cycle_cnt    = 0;
  int send_idle    = 0;          // percent of cycles the sender stays idle
  int stall_pct    = 0;          // percent of cycles the receiver stalls
  int hold_reqs    = 0;          // bumped by the sender to request a long hold-off
  int hold_seen    = 0;
  int hold_left    = 0;

  // Clock: 4 ns period.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Transform model
  // ---------------------------------------------------------------------------
  function automatic void load_register(cfg_reg_t idx, logic [62:0] v);
    case (idx)
      REG_ROT_X, REG_ROT_Y, REG_ROT_Z: begin
        for (int k = 0; k < 3; k++)
          rot_coef[int'(idx)][k] = v[k*LPRT_COEF_WIDTH +: LPRT_COEF_WIDTH];
      end
      REG_TRANSLATE: begin
        for (int k = 0; k < 3; k++)
          trans_mm[k] = v[k*TRANS_W +: TRANS_W];
      end
      REG_PASS:       pass_en = v[0];
      REG_LINE_COUNT: lines_per_scan = v[BYTE_W-1:0];
      default: ;
    endcase
  endfunction

  // Rotate, translate and stamp one point; advance the line and time state.
  function automatic xf_result_t transform_point(point_t pt);
    longint                  mm [3];
    longint                  acc;
    logic signed [OUT_W-1:0] xyz [3];
    logic [BYTE_W-1:0]       span;
    logic [BYTE_W-1:0]       scan_line;
    logic [TIME_W-1:0]       stamp;
    xf_result_t              r;
    mm[0] = longint'($signed(pt.raw_x));
    mm[1] = longint'($signed(pt.raw_y));
    mm[2] = longint'($signed(pt.raw_z));
    for (int i = 0; i < 3; i++) begin
      // cm points scale to mm first
      if (pt.low_resolution) mm[i] = mm[i] * 10;
    end
    for (int i = 0; i < 3; i++) begin
      if (pass_en) begin
        acc = mm[i] <<< OUT_FRAC;
      end else begin
        acc = longint'(trans_mm[i]) <<< FRAC;
        for (int k = 0; k < 3; k++)
          acc += mm[k] * longint'(rot_coef[i][k]);
        acc = acc >>> (FRAC - OUT_FRAC);   // floor toward minus infinity
      end
      if (acc > SAT_HI) acc = SAT_HI;
      else if (acc < SAT_LO) acc = SAT_LO;
      xyz[i] = acc[OUT_W-1:0];
    end
    // a line count of zero behaves as one line
    span = (lines_per_scan == 0) ? 8'd1 : lines_per_scan;
    if (pt.first_point) begin
      scan_line = '0;
      stamp     = pt.packet_time_ns;
    end else begin
      // restart at line 0 if the count was lowered below the position
      scan_line = (next_line >= span) ? 8'd0 : next_line;
      stamp     = next_time;
    end
    next_line = (int'(scan_line) + 1 >= int'(span)) ? 8'd0 : scan_line + 8'd1;
    next_time = stamp + pt.point_interval_ns;
    r.out_x         = xyz[0];
    r.out_y         = xyz[1];
    r.out_z         = xyz[2];
    r.intensity     = pt.reflectivity;
    r.line_number   = scan_line;
    r.out_tag       = pt.point_tag;
    r.point_time_ns = stamp;
    return r;
  endfunction

  // Append one awaited point at the tail of the ring.
  function automatic void await_put(xf_result_t r);
    awaited_ring[await_wr % AWAIT_DEPTH] = r;
    await_wr++;
  endfunction

  // Take the oldest awaited point off the ring.
  function automatic xf_result_t await_take();
    xf_result_t r;
    r = awaited_ring[await_rd % AWAIT_DEPTH];
    await_rd++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Table and stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic point_t mk_pt(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [7:0] refl, logic [7:0] tag, bit low, bit lead,
                                   logic [63:0] ptime, logic [31:0] intv);
    point_t p;
    p.raw_x             = x;
    p.raw_y             = y;
    p.raw_z             = z;
    p.reflectivity      = refl;
    p.point_tag         = tag;
    p.low_resolution    = low;
    p.first_point       = lead;
    p.packet_time_ns    = ptime;
    p.point_interval_ns = intv;
    return p;
  endfunction

  function automatic xf_result_t mk_res(longint x, longint y, longint z, logic [7:0] inten,
                                        logic [7:0] scan_line, logic [7:0] tag,
                                        logic [63:0] stamp);
    xf_result_t r;
    r.out_x         = x[OUT_W-1:0];
    r.out_y         = y[OUT_W-1:0];
    r.out_z         = z[OUT_W-1:0];
    r.intensity     = inten;
    r.line_number   = scan_line;
    r.out_tag       = tag;
    r.point_time_ns = stamp;
    return r;
  endfunction

  function automatic void add_cfg(cfg_reg_t idx, logic [62:0] v);
    vec_row_t row;
    row.kind  = ROW_CFG;
    row.ridx  = idx;
    row.rval  = v;
    row.pt    = '0;
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows[dir_cnt] = row;
    dir_cnt++;
  endfunction

  function automatic void add_pt(point_t pt, bit typed = 1'b0, xf_result_t want = '0);
    vec_row_t row;
    row.kind  = ROW_PT;
    row.ridx  = REG_ROT_X;
    row.rval  = '0;
    row.pt    = pt;
    row.typed = typed;
    row.want  = want;
    dir_rows[dir_cnt] = row;
    dir_cnt++;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(200000)) - 32'd100000;
    endcase
  endfunction

  task automatic drive_point(point_t pt);
    in_ch.raw_x             <= pt.raw_x;
    in_ch.raw_y             <= pt.raw_y;
    in_ch.raw_z             <= pt.raw_z;
    in_ch.reflectivity      <= pt.reflectivity;
    in_ch.point_tag         <= pt.point_tag;
    in_ch.low_resolution    <= pt.low_resolution;
    in_ch.first_point       <= pt.first_point;
    in_ch.packet_time_ns    <= pt.packet_time_ns;
    in_ch.point_interval_ns <= pt.point_interval_ns;
  endtask

  // Offer one item after a random idle stretch; on acceptance record what
  // the output must show for it.
  task automatic offer_point(point_t pt, bit typed = 1'b0, xf_result_t want = '0);
    xf_result_t calc;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    drive_point(pt);
    do @(posedge clk); while (!in_ch.ready);
    calc = transform_point(pt);
    await_put(typed ? want : calc);
  endtask

  // Drop valid and hold until every awaited point has come out.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (await_wr != await_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [62:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    load_register(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string msg);
    $display("ERROR @%0t result %0d: %s", $time, results_seen, msg);
    mismatch_cnt++;
  endtask

  task automatic diff_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin
    xf_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (await_wr == await_rd) begin
        note_mismatch("result with nothing awaited");
      end else begin
        want = await_take();
        diff_field("out_x", 64'(out_ch.out_x), 64'(want.out_x));
        diff_field("out_y", 64'(out_ch.out_y), 64'(want.out_y));
        diff_field("out_z", 64'(out_ch.out_z), 64'(want.out_z));
        diff_field("intensity", 64'(out_ch.intensity), 64'(want.intensity));
        diff_field("line_number", 64'(out_ch.line_number), 64'(want.line_number));
        diff_field("out_tag", 64'(out_ch.out_tag), 64'(want.out_tag));
        diff_field("point_time_ns", out_ch.point_time_ns, want.point_time_ns);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here whenever the
  // sender bumps hold_reqs.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL lidar_point_rigid_transform");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    vec_row_t    row;
    point_t      pt;
    logic [47:0] rv;
    logic [62:0] tv;
    int          sent;
    int          plen;
    int          idle_tab [5];
    int          stall_tab [5];
    int          lc_tab [5];

    idle_tab  = '{0, 70, 0, 28, 0};
    stall_tab = '{0, 0, 70, 28, 0};
    lc_tab    = '{3, 255, 0, 1, 0};

    // Drive every input to a known value before the first edge.
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_ROT_X;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    drive_point('0);

    // Model state after reset: identity rotation, no offset, one line.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++)
        rot_coef[r][c] = (r == c) ? LPRT_COEF_WIDTH'(1 << FRAC) : '0;
      trans_mm[r] = '0;
    end
    pass_en        = 1'b0;
    lines_per_scan = 8'd1;
    next_line      = '0;
    next_time      = '0;

    // Directed table. Under the reset identity a mm point comes out times 16,
    // a cm point times 160; typed rows can be checked by eye.
    add_pt(mk_pt(100, -200, 300, 8'h00, 8'hFF, 0, 1, 64'd1000, 32'd50), 1'b1,
           mk_res(1600, -3200, 4800, 8'h00, 8'd0, 8'hFF, 64'd1000));
    add_pt(mk_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'h00, 0, 0,
                 64'd0, 32'hFFFF_FFFF), 1'b1,
           mk_res(64'sd34359738352, 64'sd34359738352, 64'sd34359738352,
                  8'hFF, 8'd0, 8'h00, 64'd1050));
    add_pt(mk_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h01, 8'h80, 0, 0,
                 64'd0, 32'd0), 1'b1,
           mk_res(-64'sd34359738368, -64'sd34359738368, -64'sd34359738368,
                  8'h01, 8'd0, 8'h80, 64'd4294968345));
    // cm point, packet time at the top so the next time wraps to zero
    add_pt(mk_pt(7, -7, 0, 8'h80, 8'h01, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1), 1'b1,
           mk_res(1120, -1120, 0, 8'h80, 8'd0, 8'h01, 64'hFFFF_FFFF_FFFF_FFFF));
    add_pt(mk_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 8'h7F, 8'hFE, 1, 0,
                 64'd0, 32'd5), 1'b1,
           mk_res(64'sd343597383520, -64'sd343597383680, -160, 8'h7F, 8'd0, 8'hFE,
                  64'd0));
    add_pt(mk_pt(0, 0, 0, 8'hA5, 8'h5A, 0, 0, 64'd0, 32'd0), 1'b1,
           mk_res(0, 0, 0, 8'hA5, 8'd0, 8'h5A, 64'd5));
    // pass-through over three lines
    add_cfg(REG_PASS, 63'd1);
    add_cfg(REG_LINE_COUNT, 63'd3);
    add_pt(mk_pt(3, 4, 5, 8'h11, 8'h22, 1, 1, 64'd77, 32'd10), 1'b1,
           mk_res(480, 640, 800, 8'h11, 8'd0, 8'h22, 64'd77));
    add_pt(mk_pt(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'h33, 8'h44, 1, 0, 0, 7));
    add_pt(mk_pt(-12345, 67890, -1, 8'h55, 8'h66, 0, 0, 0, 32'hFFFF_FFFF));
    add_pt(mk_pt(1, 2, 3, 8'h77, 8'h88, 0, 0, 0, 3));
    // translation at its extremes: +max x, -max y, -1 z
    add_cfg(REG_PASS, 63'd0);
    add_cfg(REG_TRANSLATE, {21'h1F_FFFF, 21'h10_0000, 21'h0F_FFFF});
    add_pt(mk_pt(0, 0, 0, 8'h00, 8'h00, 0, 1, 64'd0, 32'd0), 1'b1,
           mk_res(16777200, -16777216, -16, 8'h00, 8'd0, 8'h00, 64'd0));
    // coefficients at -2 and just under +2 drive the x and y results into saturation
    add_cfg(REG_ROT_X, 48'h8000_8000_8000);
    add_cfg(REG_ROT_Y, 48'h7FFF_7FFF_7FFF);
    add_cfg(REG_ROT_Z, 48'hFFFF_0001_4000);
    add_pt(mk_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h9C, 8'hC9, 1, 0, 0, 9));
    add_pt(mk_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'hC9, 8'h9C, 1, 0, 0, 9));
    // line count of zero acts as one line
    add_cfg(REG_LINE_COUNT, 63'd0);
    add_pt(mk_pt(10, 20, 30, 8'h01, 8'h02, 0, 1, 64'd500, 32'd100));
    add_pt(mk_pt(40, 50, 60, 8'h03, 8'h04, 0, 0, 0, 100));
    add_pt(mk_pt(70, 80, 90, 8'h05, 8'h06, 1, 0, 0, 100));
    // lower the count mid-packet so the position is past the end
    add_cfg(REG_LINE_COUNT, 63'd5);
    add_pt(mk_pt(-10, -20, -30, 8'h07, 8'h08, 0, 1, 64'd9000, 32'd250));
    add_pt(mk_pt(-40, -50, -60, 8'h09, 8'h0A, 0, 0, 0, 250));
    add_pt(mk_pt(-70, -80, -90, 8'h0B, 8'h0C, 0, 0, 0, 250));
    add_cfg(REG_LINE_COUNT, 63'd2);
    add_pt(mk_pt(5, 5, 5, 8'h0D, 8'h0E, 0, 0, 0, 250));

    // Synchronous reset, asserted once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; register writes only once the block is empty.
    for (int n = 0; n < dir_cnt; n++) begin
      row = dir_rows[n];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.ridx, row.rval);
      end else begin
        offer_point(row.pt, row.typed, row.want);
      end
    end

    // Random phases: new configuration each, then packets of random points.
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      for (int r = 0; r < 3; r++) begin
        case ($urandom_range(4))
          0:       rv = '0;
          1:       rv = 48'hFFFF_FFFF_FFFF;
          2:       rv = ROT_ONE << (LPRT_COEF_WIDTH * r);
          default: rv = 48'({$urandom(), $urandom()});
        endcase
        write_reg(cfg_reg_t'(int'(REG_ROT_X) + r), 63'(rv));
      end
      case ($urandom_range(3))
        0:       tv = '1;
        1:       tv = '0;
        default: tv = 63'({$urandom(), $urandom()});
      endcase
      write_reg(REG_TRANSLATE, tv);
      write_reg(REG_PASS, (ph == 2 || $urandom_range(4) == 0) ? 63'd1 : 63'd0);
      write_reg(REG_LINE_COUNT, (ph == 4) ? 63'($urandom_range(2, 40)) : 63'(lc_tab[ph]));

      send_idle = idle_tab[ph];
      stall_pct <= stall_tab[ph];
      // Last phase: block the output for a long stretch while the input keeps
      // pushing, so the pipeline fills and backs up.
      if (ph == 4) hold_reqs <= hold_reqs + 1;

      sent = 0;
      while (sent < 150) begin
        plen = $urandom_range(1, 60);
        for (int k = 0; k < plen && sent < 150; k++) begin
          pt.raw_x             = pick_coord();
          pt.raw_y             = pick_coord();
          pt.raw_z             = pick_coord();
          pt.reflectivity      = $urandom();
          pt.point_tag         = $urandom();
          pt.low_resolution    = $urandom_range(1);
          pt.first_point       = (k == 0);
          pt.packet_time_ns    = {$urandom(), $urandom()};
          pt.point_interval_ns = $urandom_range(1) ? $urandom() : $urandom_range(2000);
          // scatter stray packet starts and missing ones
          if ($urandom_range(9) == 0) pt.first_point = $urandom_range(1);
          offer_point(pt);
          sent++;
          // pause the sender until the pipeline has fully drained
          if (ph == 4 && sent == 80) settle();
        end
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("PASS lidar_point_rigid_transform");
    end else begin
      $display("FAIL lidar_point_rigid_transform");
    end
    $finish;
  end

endmodule
